### sv/brsc_pkg.sv
// Shared constants, types and helper functions of the bounded run sequence counter.
package brsc_pkg;

  // Largest count that the table covers; larger input counts saturate to it.
  localparam int MAX_COUNT  = 128;
  localparam int TABLE_SIDE = MAX_COUNT + 1;
  localparam int CNT_W      = $clog2(TABLE_SIDE);
  localparam int ADDR_W     = $clog2(TABLE_SIDE * TABLE_SIDE);
  localparam int FIELD_W    = 8;
  localparam int CMP_W      = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;
  localparam int VAL_W      = 27;

  localparam logic [VAL_W-1:0] MODULUS = VAL_W'(100000000);

  // Configuration register indexes.
  localparam logic REG_MAX_RUN_A = 1'b0;
  localparam logic REG_MAX_RUN_B = 1'b1;

  // Operations of the shared modular unit.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Read and write controls from the sequencer to the prefix-sum tables.
  typedef struct packed {
    addr_t p1_raddr_hi;
    addr_t p1_raddr_lo;
    cnt_t  p0_raddr;
    logic  p1_we;
    addr_t p1_waddr;
    logic  p0_we;
    cnt_t  p0_waddr;
  } tbl_req_t;

  // Clamp an input count to the covered range.
  function automatic cnt_t sat_count(input logic [FIELD_W-1:0] c);
    if (int'(c) > MAX_COUNT) begin
      return CNT_W'(MAX_COUNT);
    end
    return CNT_W'(c);
  endfunction

  // Flat address of table entry (row, col).
  function automatic addr_t cell_addr(input cnt_t row, input cnt_t col);
    return ADDR_W'(row) * ADDR_W'(TABLE_SIDE) + ADDR_W'(col);
  endfunction

endpackage

### sv/bounded_run_sequence_counter.sv
// Top level of the bounded run sequence counter: handshakes, registers and sequencer.
//
// Each input word carries count_a and count_b. The block returns, modulo
// 100000000, the number of sequences of that many A and B items in which no
// run of A is longer than max_run_a and no run of B longer than max_run_b.
// Counts above 128 are taken as 128. The user must write the run limits via cfg_we /
// cfg_index / cfg_data port while the block is idle; it does not enforce this.
//
// Both channels use valid and stall. item_stall is high while a word is in
// work; the block takes one word at a time. If either count is zero the
// result is known at once and goes straight to the emit step. Otherwise the
// sequencer walks all (a, b) cells up to (count_a, count_b); each cell takes
// one table read and four passes through the single modular adder. Then the
// sequencer adds the final pair and loads the result.
// A finished result sits in the output register until taken; a new word is
// accepted meanwhile, and a later result waits while result_stall is high.
// Reset clears the output, idles the sequencer and sets both limits to 10.
// The tables need no clearing: every entry is written before it is read.
module bounded_run_sequence_counter import brsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [FIELD_W-1:0]   count_a,
  input  logic [FIELD_W-1:0]   count_b,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [VAL_W-1:0]     arrangements
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_V0   = 3'd2;
  localparam logic [2:0] ST_V1   = 3'd3;
  localparam logic [2:0] ST_P1   = 3'd4;
  localparam logic [2:0] ST_P0   = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]         state;
  logic [FIELD_W-1:0] max_run_a;
  logic [FIELD_W-1:0] max_run_b;
  cnt_t               na;
  cnt_t               nb;
  cnt_t               a_cnt;
  cnt_t               b_cnt;
  val_t               v0;
  val_t               v1;
  val_t               p0_prev;
  val_t               res;

  cnt_t               in_a;
  cnt_t               in_b;
  logic               base_cell;
  val_t               base_val;
  logic               lo_a_ok;
  logic               lo_b_ok;
  cnt_t               hi_row;
  cnt_t               lo_row;
  cnt_t               lo_col;
  logic               last_cell;
  logic               out_free;

  logic               alu_op;
  val_t               alu_x;
  val_t               alu_y;
  val_t               alu_res;
  tbl_req_t           tbl_req;
  val_t               p1_hi;
  val_t               p1_lo;
  val_t               p0_lo;

  // Saturated input counts and per-cell conditions.
  always_comb begin
    in_a      = sat_count(count_a);
    in_b      = sat_count(count_b);
    base_cell = (a_cnt == '0) || (b_cnt == '0);
    if ((a_cnt == '0) && (b_cnt == '0)) begin
      base_val = VAL_W'(1);
    end else if (a_cnt == '0) begin
      base_val = VAL_W'(CMP_W'(b_cnt) <= CMP_W'(max_run_b));
    end else begin
      base_val = VAL_W'(CMP_W'(a_cnt) <= CMP_W'(max_run_a));
    end
    lo_a_ok   = CMP_W'(a_cnt) > CMP_W'(max_run_a);
    lo_b_ok   = CMP_W'(b_cnt) > CMP_W'(max_run_b);
    hi_row    = (a_cnt == '0) ? '0 : a_cnt - 1'b1;
    lo_row    = lo_a_ok ? CNT_W'(CMP_W'(a_cnt) - CMP_W'(max_run_a) - CMP_W'(1)) : '0;
    lo_col    = lo_b_ok ? CNT_W'(CMP_W'(b_cnt) - CMP_W'(max_run_b) - CMP_W'(1)) : '0;
    last_cell = (a_cnt == na) && (b_cnt == nb);
    out_free  = !result_valid || !result_stall;
  end

  // Table addresses and write strobes.
  always_comb begin
    tbl_req.p1_raddr_hi = cell_addr(hi_row, b_cnt);
    tbl_req.p1_raddr_lo = cell_addr(lo_row, b_cnt);
    tbl_req.p0_raddr    = lo_col;
    tbl_req.p1_we       = (state == ST_P1);
    tbl_req.p1_waddr    = cell_addr(a_cnt, b_cnt);
    tbl_req.p0_we       = (state == ST_P0);
    tbl_req.p0_waddr    = b_cnt;
  end

  // Operand selection for the shared modular unit.
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = '0;
    alu_y  = '0;
    case (state)
      ST_V0: begin
        alu_op = ALU_SUB;
        alu_x  = p1_hi;
        alu_y  = lo_a_ok ? p1_lo : '0;
      end
      ST_V1: begin
        alu_op = ALU_SUB;
        alu_x  = p0_prev;
        alu_y  = lo_b_ok ? p0_lo : '0;
      end
      ST_P1: begin
        alu_x = (a_cnt == '0) ? '0 : p1_hi;
        alu_y = v1;
      end
      ST_P0: begin
        alu_x = (b_cnt == '0) ? '0 : p0_prev;
        alu_y = v0;
      end
      ST_SUM: begin
        alu_x = v0;
        alu_y = v1;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  brsc_modalu u_alu (
    .op     (alu_op),
    .x      (alu_x),
    .y      (alu_y),
    .result (alu_res)
  );

  brsc_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .wdata (alu_res),
    .p1_hi (p1_hi),
    .p1_lo (p1_lo),
    .p0_lo (p0_lo)
  );

  assign item_stall = (state != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_a <= FIELD_W'(10);
      max_run_b <= FIELD_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RUN_A: max_run_a <= cfg_data;
        REG_MAX_RUN_B: max_run_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer over the table cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            na    <= in_a;
            nb    <= in_b;
            a_cnt <= '0;
            b_cnt <= '0;
            if ((in_a == '0) && (in_b == '0)) begin
              res   <= VAL_W'(1);
              state <= ST_EMIT;
            end else if (in_a == '0) begin
              res   <= VAL_W'(CMP_W'(in_b) <= CMP_W'(max_run_b));
              state <= ST_EMIT;
            end else if (in_b == '0) begin
              res   <= VAL_W'(CMP_W'(in_a) <= CMP_W'(max_run_a));
              state <= ST_EMIT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_V0;
        end
        ST_V0: begin
          v0    <= base_cell ? base_val : alu_res;
          state <= ST_V1;
        end
        ST_V1: begin
          v1    <= base_cell ? base_val : alu_res;
          state <= ST_P1;
        end
        ST_P1: begin
          state <= ST_P0;
        end
        ST_P0: begin
          p0_prev <= alu_res;
          if (last_cell) begin
            state <= ST_SUM;
          end else if (b_cnt == nb) begin
            b_cnt <= '0;
            a_cnt <= a_cnt + 1'b1;
            state <= ST_READ;
          end else begin
            b_cnt <= b_cnt + 1'b1;
            state <= ST_READ;
          end
        end
        ST_SUM: begin
          res   <= alu_res;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      arrangements <= res;
    end
  end

  // A new result appears only out of the emit step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EMIT)
    else $error("result appeared outside the emit step");

  // The cell walk never leaves the requested rectangle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_V0 || state == ST_V1 ||
     state == ST_P1 || state == ST_P0) |-> (a_cnt <= na && b_cnt <= nb))
    else $error("cell counters out of range");

  // The running row sum stays reduced below the modulus.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_P0 |=> p0_prev < MODULUS)
    else $error("row sum not reduced");

  // A delivered result is always reduced.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> arrangements < MODULUS)
    else $error("result not reduced");

endmodule

### sv/brsc_modalu.sv
// Shared modular add and subtract unit, modulo 100000000.
module brsc_modalu import brsc_pkg::*; (
  input  logic op,
  input  val_t x,
  input  val_t y,
  output val_t result
);

  logic [VAL_W:0] sum;
  logic [VAL_W:0] diff;

  // Both operands are below the modulus, so one correction step suffices.
  always_comb begin
    sum  = {1'b0, x} + {1'b0, y};
    diff = {1'b0, x} - {1'b0, y};
    case (op)
      ALU_ADD: begin
        if (sum >= {1'b0, MODULUS}) begin
          result = VAL_W'(sum - {1'b0, MODULUS});
        end else begin
          result = VAL_W'(sum);
        end
      end
      ALU_SUB: begin
        if (x < y) begin
          result = VAL_W'(diff + {1'b0, MODULUS});
        end else begin
          result = VAL_W'(diff);
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

### sv/brsc_table.sv
// Prefix-sum tables: column sums of B-next counts and the row sums of A-next counts.
module brsc_table import brsc_pkg::*; (
  input  logic     clk,
  input  tbl_req_t req,
  input  val_t     wdata,
  output val_t     p1_hi,
  output val_t     p1_lo,
  output val_t     p0_lo
);

  // Running sums over rows of B-next counts, one entry per (a, b).
  val_t p1_mem [TABLE_SIDE*TABLE_SIDE];
  // Running sums along the current row of A-next counts, one entry per b.
  val_t p0_mem [TABLE_SIDE];

  // Writes and registered reads of the full table.
  always_ff @(posedge clk) begin
    if (req.p1_we) begin
      p1_mem[req.p1_waddr] <= wdata;
    end
    p1_hi <= p1_mem[req.p1_raddr_hi];
    p1_lo <= p1_mem[req.p1_raddr_lo];
  end

  // Writes and registered read of the row table.
  always_ff @(posedge clk) begin
    if (req.p0_we) begin
      p0_mem[req.p0_waddr] <= wdata;
    end
    p0_lo <= p0_mem[req.p0_raddr];
  end

endmodule
